// File: hdl/clip_pkg.sv
// shared types, character codes and helpers for the command line integer parser
package clip_pkg;

  localparam int MAX_PARAMS = 8;
  localparam int CNT_W      = $clog2(MAX_PARAMS);
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int DATA_W     = 40;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SUB   = 8'h1A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LFH   = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WORD,
    PH_GAP,
    PH_NUM,
    PH_FRAC,
    PH_PEND,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NOP  = 2'd1,
    ST_BAD  = 2'd2,
    ST_MANY = 2'd3
  } status_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
    logic [2:0]         param_index;
    logic [1:0]         status;
    logic [2:0]         param_count;
    logic               last;
  } res_t;

  // results produced by one byte, in order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
           c == CH_FF || c == CH_SUB;
  endfunction

endpackage

// File: hdl/clip_parser.sv
// per-byte parser state and result generation
module clip_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          ch,
  output clip_pkg::res_pair_t res
);

  clip_pkg::phase_t                phase, phase_next;
  logic [31:0]                     acc, acc_next;
  logic                            neg, neg_next;
  logic                            hex, hex_next;
  logic [clip_pkg::CNT_W-1:0]      count, count_next;
  logic [1:0]                      err, err_next;

  logic                            sp;
  logic                            do_num;
  logic [31:0]                     acc_b;
  logic                            neg_b;
  logic                            hex_b;
  logic [31:0]                     scaled;
  logic [3:0]                      digit;
  logic                            is_dec;
  logic                            is_hexl;
  logic [clip_pkg::CNT_W-1:0]      count_inc;
  clip_pkg::res_t                  p_res;
  clip_pkg::res_t                  s_res;
  clip_pkg::res_pair_t             out;

  assign sp        = clip_pkg::is_space(ch);
  assign count_inc = count + 1'b1;

  // a number starting from the gap begins with a fresh accumulator
  assign acc_b = (phase == clip_pkg::PH_GAP) ? 32'd0 : acc;
  assign neg_b = (phase == clip_pkg::PH_GAP) ? 1'b0 : neg;
  assign hex_b = (phase == clip_pkg::PH_GAP) ? 1'b0 : hex;

  assign is_dec  = ch >= clip_pkg::CH_ZERO && ch <= clip_pkg::CH_NINE;
  assign is_hexl = hex_b && ((ch >= clip_pkg::CH_LA && ch <= clip_pkg::CH_LFH) ||
                             (ch >= clip_pkg::CH_UA && ch <= clip_pkg::CH_UF));
  assign digit   = is_dec ? ch[3:0] : ch[3:0] + 4'd9;
  assign scaled  = hex_b ? {acc_b[27:0], 4'd0} : {acc_b[28:0], 3'd0} + {acc_b[30:0], 1'b0};

  always_comb begin
    p_res             = '0;
    p_res.kind        = 1'b0;
    p_res.value       = neg_b ? -acc_b : acc_b;
    p_res.param_index = 3'(count);
    s_res             = '0;
    s_res.kind        = 1'b1;
    s_res.last        = 1'b1;
  end

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    neg_next   = neg;
    hex_next   = hex;
    count_next = count;
    err_next   = err;
    do_num     = 1'b0;
    out        = '0;

    unique case (phase)
      clip_pkg::PH_IDLE: begin
        if (ch == clip_pkg::CH_NUL) begin
          out.n  = 2'd1;
          out.r0 = s_res;
          out.r0.status      = clip_pkg::ST_NOP;
          out.r0.param_count = 3'(count);
          phase_next = clip_pkg::PH_IDLE;
        end else if (!sp) begin
          phase_next = clip_pkg::PH_WORD;
        end
      end
      clip_pkg::PH_WORD: begin
        if (ch == clip_pkg::CH_NUL) begin
          out.n  = 2'd1;
          out.r0 = s_res;
          out.r0.status      = clip_pkg::ST_OK;
          out.r0.param_count = 3'(count);
          phase_next = clip_pkg::PH_IDLE;
          count_next = '0;
        end else if (sp) begin
          phase_next = clip_pkg::PH_GAP;
        end
      end
      clip_pkg::PH_GAP: begin
        if (ch == clip_pkg::CH_NUL) begin
          out.n  = 2'd1;
          out.r0 = s_res;
          out.r0.status      = clip_pkg::ST_OK;
          out.r0.param_count = 3'(count);
          phase_next = clip_pkg::PH_IDLE;
          count_next = '0;
        end else if (!sp) begin
          if (32'(count) >= 32'(clip_pkg::MAX_PARAMS - 1)) begin
            err_next   = clip_pkg::ST_MANY;
            phase_next = clip_pkg::PH_SKIP;
          end else begin
            acc_next   = '0;
            neg_next   = 1'b0;
            hex_next   = 1'b0;
            phase_next = clip_pkg::PH_NUM;
            do_num     = 1'b1;
          end
        end
      end
      clip_pkg::PH_NUM: begin
        do_num = 1'b1;
      end
      clip_pkg::PH_FRAC, clip_pkg::PH_PEND: begin
        if (ch == clip_pkg::CH_NUL) begin
          out.n  = 2'd2;
          out.r0 = p_res;
          out.r1 = s_res;
          out.r1.status      = clip_pkg::ST_OK;
          out.r1.param_count = 3'(count_inc);
          phase_next = clip_pkg::PH_IDLE;
          count_next = '0;
        end else if (phase == clip_pkg::PH_FRAC && ch == clip_pkg::CH_SPACE) begin
          out.n  = 2'd1;
          out.r0 = p_res;
          out.r0.last = 1'b1;
          count_next = count_inc;
          phase_next = clip_pkg::PH_GAP;
        end else if (phase == clip_pkg::PH_PEND && !sp) begin
          err_next   = clip_pkg::ST_BAD;
          phase_next = clip_pkg::PH_SKIP;
        end
      end
      default: begin
        if (ch == clip_pkg::CH_NUL) begin
          out.n  = 2'd1;
          out.r0 = s_res;
          out.r0.status      = err;
          out.r0.param_count = 3'(count);
          phase_next = clip_pkg::PH_IDLE;
          count_next = '0;
        end
      end
    endcase

    // byte inside a number, before any point
    if (do_num) begin
      priority if (ch == clip_pkg::CH_NUL) begin
        out.n  = 2'd2;
        out.r0 = p_res;
        out.r1 = s_res;
        out.r1.status      = clip_pkg::ST_OK;
        out.r1.param_count = 3'(count_inc);
        phase_next = clip_pkg::PH_IDLE;
        count_next = '0;
      end else if (ch == clip_pkg::CH_SPACE) begin
        out.n  = 2'd1;
        out.r0 = p_res;
        out.r0.last = 1'b1;
        count_next = count_inc;
        phase_next = clip_pkg::PH_GAP;
      end else if (ch == clip_pkg::CH_DOT) begin
        phase_next = clip_pkg::PH_FRAC;
      end else if (ch == clip_pkg::CH_MINUS) begin
        neg_next = 1'b1;
      end else if (ch == clip_pkg::CH_LX || ch == clip_pkg::CH_UX) begin
        hex_next = 1'b1;
      end else if (is_dec || is_hexl) begin
        acc_next = scaled + {28'd0, digit};
      end else if (sp) begin
        phase_next = clip_pkg::PH_PEND;
      end else begin
        err_next   = clip_pkg::ST_BAD;
        phase_next = clip_pkg::PH_SKIP;
      end
    end

    // end of line clears everything
    if (phase_next == clip_pkg::PH_IDLE && ch == clip_pkg::CH_NUL) begin
      acc_next   = '0;
      neg_next   = 1'b0;
      hex_next   = 1'b0;
      count_next = '0;
      err_next   = clip_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= clip_pkg::PH_IDLE;
      acc   <= '0;
      neg   <= 1'b0;
      hex   <= 1'b0;
      count <= '0;
      err   <= clip_pkg::ST_OK;
    end else if (take) begin
      phase <= phase_next;
      acc   <= acc_next;
      neg   <= neg_next;
      hex   <= hex_next;
      count <= count_next;
      err   <= err_next;
    end
  end

  always_comb begin
    res   = out;
    res.n = take ? out.n : 2'd0;
  end

endmodule

// File: hdl/clip_fifo.sv
// small result queue taking up to two results per cycle
module clip_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  clip_pkg::res_pair_t              wr,
  output logic                             room,
  output logic                             rd_valid,
  input  logic                             rd_ready,
  output clip_pkg::res_t                   rd_data
);

  clip_pkg::res_t                  mem [clip_pkg::FIFO_DEPTH];
  logic [clip_pkg::PTR_W-1:0]      wptr, rptr;
  logic [clip_pkg::FCNT_W-1:0]     cnt;
  logic                            pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = cnt != '0;
  assign rd_data  = mem[rptr];
  assign room     = 32'(cnt) <= 32'(clip_pkg::FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (wr.n != 2'd0) begin
      mem[wptr] <= wr.r0;
    end
    if (wr.n == 2'd2) begin
      mem[wptr + 1'b1] <= wr.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= wptr + clip_pkg::PTR_W'(wr.n);
      rptr <= rptr + clip_pkg::PTR_W'(pop);
      cnt  <= cnt + clip_pkg::FCNT_W'(wr.n) - clip_pkg::FCNT_W'(pop);
    end
  end

endmodule

// File: hdl/command_line_integer_parser.sv
// top level of the streaming command line integer parser
//
// takes one byte of a command line per transfer (byte 0 ends the line), skips
// the leading function word and emits each following word as a signed 32-bit
// integer with its position, then one status result at the end of the line.
// a byte is accepted every cycle while the result queue has room for two
// results; the parser state updates in the same cycle, so the sustained rate
// is one byte per cycle. a line end that closes a number yields two results
// (parameter, then status), which drain one per cycle while m_tready is high from
// a four-entry queue; results are registered in the queue before they go out.
module command_line_integer_parser (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // ch[7:0]
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [clip_pkg::DATA_W-1:0]   m_tdata,   // value[31:0], param_index[34:32],
                                                   // status[36:35], param_count[39:37]
  output logic                          m_tuser,   // kind: 0 parameter, 1 line status
  output logic                          m_tlast    // final result of this byte
);

  clip_pkg::res_pair_t res;
  clip_pkg::res_t      head;
  logic                room;
  logic                take;

  // byte transfer
  assign take     = s_tvalid && room;
  assign s_tready = room;

  clip_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .ch   (s_tdata),
    .res  (res)
  );

  // results queue, decouples parser from downstream stalls
  clip_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (res),
    .room     (room),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (head)
  );

  assign m_tdata = {head.param_count, head.status, head.param_index, head.value};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

// File: tb/sv/clip_result_checker.sv
// result checker for the command line integer parser: line state tracking and per-field compare
`timescale 1ns / 1ps
module clip_result_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // ch[7:0]
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [clip_pkg::DATA_W-1:0] m_tdata,   // value[31:0], param_index[34:32],
                                                 // status[36:35], param_count[39:37]
  input  logic                        m_tuser,   // kind
  input  logic                        m_tlast,   // last result of the byte
  output int                          mismatches,
  output int                          outstanding,
  output int                          params_seen,
  output int                          statuses_seen
);
  import clip_pkg::*;

  // line state as the parser should hold it
  phase_t      ph;
  logic [31:0] acc;
  logic        neg;
  logic        hex;
  int          cnt;
  status_t     err;

  res_t        expected_results[$];

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_FF ||
           c == CH_CR || c == CH_SUB;
  endfunction

  task automatic close_line();
    ph  = PH_IDLE;
    acc = '0;
    neg = 1'b0;
    hex = 1'b0;
    cnt = 0;
    err = ST_OK;
  endtask

  task automatic emit_param(input logic fin);
    res_t r;
    r             = '0;
    r.kind        = 1'b0;
    r.value       = neg ? -acc : acc;
    r.param_index = cnt[2:0];
    r.last        = fin;
    expected_results.push_back(r);
    cnt++;
  endtask

  task automatic emit_status(input status_t st);
    res_t r;
    r             = '0;
    r.kind        = 1'b1;
    r.status      = st;
    r.param_count = cnt[2:0];
    r.last        = 1'b1;
    expected_results.push_back(r);
  endtask

  // a byte inside a number, before any dot
  task automatic number_char(input logic [7:0] c);
    if (c == CH_NUL) begin
      emit_param(1'b0);
      emit_status(ST_OK);
      close_line();
    end else if (c == CH_SPACE) begin
      emit_param(1'b1);
      ph = PH_GAP;
    end else if (c == CH_DOT) begin
      ph = PH_FRAC;
    end else if (c == CH_MINUS) begin
      neg = 1'b1;
    end else if (c == CH_LX || c == CH_UX) begin
      hex = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      acc = acc * (hex ? 32'd16 : 32'd10) + (c - CH_ZERO);
    end else if (hex && c >= CH_LA && c <= CH_LFH) begin
      acc = (acc << 4) + (c - CH_LA + 32'd10);
    end else if (hex && c >= CH_UA && c <= CH_UF) begin
      acc = (acc << 4) + (c - CH_UA + 32'd10);
    end else if (is_blank(c)) begin
      ph = PH_PEND;
    end else begin
      err = ST_BAD;
      ph  = PH_SKIP;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    case (ph)
      PH_IDLE: begin
        if (c == CH_NUL) begin
          emit_status(ST_NOP);
          close_line();
        end else if (!is_blank(c)) begin
          ph = PH_WORD;
        end
      end
      PH_WORD: begin
        if (c == CH_NUL) begin
          emit_status(ST_OK);
          close_line();
        end else if (is_blank(c)) begin
          ph = PH_GAP;
        end
      end
      PH_GAP: begin
        if (c == CH_NUL) begin
          emit_status(ST_OK);
          close_line();
        end else if (!is_blank(c)) begin
          if (cnt >= MAX_PARAMS - 1) begin
            err = ST_MANY;
            ph  = PH_SKIP;
          end else begin
            acc = '0;
            neg = 1'b0;
            hex = 1'b0;
            ph  = PH_NUM;
            number_char(c);
          end
        end
      end
      PH_NUM: number_char(c);
      PH_FRAC: begin
        if (c == CH_NUL) begin
          emit_param(1'b0);
          emit_status(ST_OK);
          close_line();
        end else if (c == CH_SPACE) begin
          emit_param(1'b1);
          ph = PH_GAP;
        end
      end
      PH_PEND: begin
        if (c == CH_NUL) begin
          emit_param(1'b0);
          emit_status(ST_OK);
          close_line();
        end else if (!is_blank(c)) begin
          err = ST_BAD;
          ph  = PH_SKIP;
        end
      end
      default: begin
        if (c == CH_NUL) begin
          emit_status(err);
          close_line();
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      expected_results.delete();
      close_line();
      mismatches    = 0;
      params_seen   = 0;
      statuses_seen = 0;
    end else begin
      // a result never comes from the byte taken at the same edge
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: tdata %0h, tuser %0b",
                 m_tdata, m_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(m_tuser));
          check_field("value", want.value, m_tdata[31:0]);
          check_field("param_index", 32'(want.param_index), 32'(m_tdata[34:32]));
          check_field("status", 32'(want.status), 32'(m_tdata[36:35]));
          check_field("param_count", 32'(want.param_count), 32'(m_tdata[39:37]));
          check_field("last", 32'(want.last), 32'(m_tlast));
          if (want.kind) statuses_seen++;
          else params_seen++;
        end
      end
      if (s_tvalid && s_tready) parse_char(s_tdata);
    end
    outstanding = expected_results.size();
  end

endmodule

// File: tb/sv/tb_command_line_integer_parser.sv
// testbench top for the command line integer parser: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_command_line_integer_parser;
  import clip_pkg::*;

  localparam int RANDOM_BYTES = 400;   // random part stops once this many bytes went in
  localparam int QUIET_BYTES  = 340;   // no idling on either side after this point
  localparam int HOLD_CYCLES  = 200;   // one long result stall
  localparam int DRAIN_CYCLES = 8;     // settle time after the last expected result

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = 8'h00;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  // idling control: idling_on shared by the sender and the receiver, the long hold for the receiver
  logic idling_on  = 1'b1;
  logic long_hold  = 1'b0;
  logic hold_taken = 1'b0;

  int mismatches;
  int outstanding;
  int params_seen;
  int statuses_seen;
  int bytes_sent = 0;
  int lines_sent = 0;

  // bytes of the line being sent, ending in the terminating zero
  logic [7:0] line_buf[$];

  always #1 clk = ~clk;

  command_line_integer_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  clip_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .params_seen   (params_seen),
    .statuses_seen (statuses_seen)
  );

  // any of the six whitespace codes
  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_FF;
      4: return CH_CR;
      default: return CH_SUB;
    endcase
  endfunction

  // any nonzero byte that is not whitespace, high bytes included
  function automatic logic [7:0] pick_word_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (is_space(c)) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // decimal digit, or hex digit in mixed case
  function automatic logic [7:0] pick_digit(input bit in_hex);
    logic [7:0] d;
    d = in_hex ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 9));
    if (d < 10) return CH_ZERO + d;
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 8'd10;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // one number word: optional minus (front or late), optional hex prefix, digits,
  // now and then a stray byte, and sometimes a fraction that gets ignored
  task automatic add_number();
    int digits;
    bit in_hex;
    bit minus_first;
    bit minus_late;
    logic [7:0] c;
    in_hex      = ($urandom_range(0, 2) == 0);
    digits      = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
    minus_first = ($urandom_range(0, 3) == 0);
    minus_late  = !minus_first && ($urandom_range(0, 7) == 0);
    if (minus_first) line_buf.push_back(CH_MINUS);
    if (in_hex) begin
      if ($urandom_range(0, 1)) line_buf.push_back(CH_ZERO);
      line_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
    end
    repeat (digits) begin
      line_buf.push_back(pick_digit(in_hex));
      if ($urandom_range(0, 39) == 0) line_buf.push_back(pick_word_char());
    end
    if (minus_late) line_buf.push_back(CH_MINUS);
    if ($urandom_range(0, 4) == 0) begin
      line_buf.push_back(CH_DOT);
      // anything but a space or a zero is skipped after the dot
      repeat ($urandom_range(0, 3)) begin
        c = 8'($urandom_range(1, 255));
        if (c == CH_SPACE) c = CH_TAB;
        line_buf.push_back(c);
      end
    end
  endtask

  // mostly well-formed command lines, some noise and blank lines
  task automatic make_line(input int line_no);
    int roll;
    int nparm;
    line_buf.delete();
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(1, 255)));
    end else if (roll < 9) begin
      repeat ($urandom_range(0, 3)) line_buf.push_back(pick_blank());
    end else begin
      repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
      repeat ($urandom_range(1, 4)) line_buf.push_back(pick_word_char());
      // every seventh line, unless it is noise or blank, reaches the parameter limit
      if (line_no % 7 == 3) nparm = MAX_PARAMS;
      else if ($urandom_range(0, 9) == 0) nparm = $urandom_range(MAX_PARAMS - 2, MAX_PARAMS + 1);
      else nparm = $urandom_range(0, 4);
      repeat (nparm) begin
        // a number has to end at a space to let the next one start
        line_buf.push_back(CH_SPACE);
        if ($urandom_range(0, 3) == 0) line_buf.push_back(pick_blank());
        add_number();
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(pick_blank());
    end
    line_buf.push_back(CH_NUL);
  endtask

  // one byte transfer; called at a falling edge and returns at one, with valid
  // still high so the next call can keep it up without a gap
  task automatic send_byte(input logic [7:0] c);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    push_text(s);
    line_buf.push_back(CH_NUL);
    send_line();
  endtask

  // result side: random stall bursts, one long hold on request
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (long_hold && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    int start_count;
    int line_no;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed lines
    send_text("");              // empty line gives a nop
    send_text("\t");            // whitespace only, also a nop
    send_text("f -9.5 xfF");    // minus, ignored fraction, mixed-case hex ending at the zero
    send_text("f 1\r");         // number closed by other whitespace, then only whitespace
    send_text("f 2\tq");        // same, but a word follows: bad number
    line_buf.delete();          // high bytes: function word, then a bad character
    line_buf.push_back(8'hFF);
    push_text(" 9");
    line_buf.push_back(8'hC0);
    line_buf.push_back(CH_NUL);
    send_line();

    // random lines
    start_count = bytes_sent;
    line_no     = 0;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      if (bytes_sent - start_count >= QUIET_BYTES) idling_on <= 1'b0;
      else idling_on <= ($urandom_range(0, 3) != 0);
      // the receiver stalls for a long time while bytes keep coming
      if (line_no == 6) long_hold <= 1'b1;
      // sender stops until every result so far has come out
      if (line_no == 14) begin
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
      end
      make_line(line_no);
      send_line();
      line_no++;
    end
    s_tvalid <= 1'b0;

    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d bytes in %0d lines: %0d parameters and %0d line statuses checked",
             bytes_sent, lines_sent, params_seen, statuses_seen);
    $display("with idle bursts on both sides, one long result stall and one drain pause");
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // generous limit, far above the slowest correct run
  initial begin : watchdog
    #1000000;
    $display("timed out with %0d results outstanding", outstanding);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
